/* hw/rtl/tmel_pkg.sv */
// ----------------------------------------------------------------------------
// Tone melody player package
// Command codes, piano key frequency table and fixed widths shared by the
// tone melody player modules.
// ----------------------------------------------------------------------------
package tmel_pkg;

    // Command codes of an input transaction.
    localparam logic [2:0] CMD_TICK  = 3'd0;
    localparam logic [2:0] CMD_BEEP  = 3'd1;
    localparam logic [2:0] CMD_PLAY  = 3'd2;
    localparam logic [2:0] CMD_WRITE = 3'd3;
    localparam logic [2:0] CMD_OFF   = 3'd4;

    // Configuration register indexes.
    localparam logic CFG_REPEAT_KEY = 1'b0;
    localparam logic CFG_END_KEY    = 1'b1;

    localparam int ENTRY_W = 24;
    localparam int FREQ_W  = 16;

    localparam logic [7:0] KEY_COUNT   = 8'd89;
    localparam logic [7:0] COMPARE_MAX = 8'd255;

    typedef logic [FREQ_W-1:0] t_freq;

    // Note frequency in hertz of each piano key; key 0 is a pause.
    localparam t_freq KEY_FREQ [0:88] = '{
        16'd0,    16'd27,   16'd29,   16'd31,   16'd33,   16'd35,   16'd37,
        16'd39,   16'd41,   16'd44,   16'd46,   16'd49,   16'd52,   16'd55,
        16'd58,   16'd62,   16'd65,   16'd69,   16'd73,   16'd78,   16'd82,
        16'd87,   16'd92,   16'd98,   16'd104,  16'd110,  16'd117,  16'd123,
        16'd131,  16'd139,  16'd147,  16'd156,  16'd165,  16'd175,  16'd185,
        16'd196,  16'd208,  16'd220,  16'd233,  16'd247,  16'd262,  16'd277,
        16'd294,  16'd311,  16'd330,  16'd349,  16'd370,  16'd392,  16'd415,
        16'd440,  16'd466,  16'd494,  16'd523,  16'd554,  16'd587,  16'd622,
        16'd659,  16'd698,  16'd740,  16'd784,  16'd831,  16'd880,  16'd932,
        16'd988,  16'd1047, 16'd1109, 16'd1175, 16'd1245, 16'd1319, 16'd1397,
        16'd1480, 16'd1568, 16'd1661, 16'd1760, 16'd1865, 16'd1976, 16'd2093,
        16'd2217, 16'd2349, 16'd2489, 16'd2637, 16'd2794, 16'd2960, 16'd3136,
        16'd3322, 16'd3520, 16'd3729, 16'd3951, 16'd4186
    };

endpackage

/* hw/rtl/tmel_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tmel_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/tmel_div.sv */
// ----------------------------------------------------------------------------
// Serial divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tmel_div #(
    parameter int DW = 17
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [DW-1:0]              i_dividend,
    input  logic [tmel_pkg::FREQ_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [DW-1:0]              o_quotient
);

    localparam int CW = $clog2(DW + 1);

    logic                        r_active;
    logic [CW-1:0]               r_cnt;
    logic [DW-1:0]               r_dvd;
    logic [tmel_pkg::FREQ_W-1:0] r_rem;
    logic [tmel_pkg::FREQ_W-1:0] r_dvs;
    logic [tmel_pkg::FREQ_W:0]   rem_shift;
    logic [tmel_pkg::FREQ_W:0]   rem_diff;
    logic                        fits;

    assign rem_shift = {r_rem, r_dvd[DW-1]};
    assign rem_diff  = rem_shift - {1'b0, r_dvs};
    assign fits      = (rem_shift >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_cnt    <= '0;
        end else if (i_start) begin
            r_active <= 1'b1;
            r_cnt    <= CW'(DW);
        end else if (r_active) begin
            if (r_cnt == '0) begin
                r_active <= 1'b0;
            end else begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_active && (r_cnt != '0)) begin
            r_dvd <= {r_dvd[DW-2:0], fits};
            r_rem <= fits ? rem_diff[tmel_pkg::FREQ_W-1:0]
                          : rem_shift[tmel_pkg::FREQ_W-1:0];
        end
    end

    assign o_done     = r_active && (r_cnt == '0);
    assign o_quotient = r_dvd;

endmodule

/* hw/rtl/tone_melody_player_core.sv */
// ----------------------------------------------------------------------------
// Tone melody player core
// Buzzer tone and tune sequencer built around one shared serial divider.
// ----------------------------------------------------------------------------
// Usage: each input transaction carries one command (tick, beep, play from an
// index, write a tune entry, tone off) and produces exactly one output
// transaction that reports the tone enable, the tone compare value, the task
// step result and whether a tune is loaded. The input channel is stalled
// while a command is being worked on; a finished result waits in the output
// register, so the next command can be accepted while it is still pending.
// Path from acceptance to the output valid: tone off, play, a tune entry write,
// an ignored code, a silent beep and a tick that needs no new note pass the
// execute state straight to the result state; a tick that fetches a marker or
// a silent note passes the fetch state as well. A sounding beep runs the
// shared restoring divider once for the rounded compare value in the divide
// state; a tick that fetches a sounding note passes the fetch state before
// the divide state. Once the result is loaded the block returns to idle and
// takes the next command.
// Reset clears the sequencer, the timer and the tune state and sets the
// repeat and end keys to 254 and 255; the tune memory is not cleared and
// must be written before it is played. When the receiver stalls, the result
// holds and the block finishes at most one further command before it waits.
// Configuration writes are taken at any time and must come while idle.
// ----------------------------------------------------------------------------
module tone_melody_player_core #(
    parameter int TUNE_DEPTH   = 256,
    parameter int TONE_BASE_HZ = 57600
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    // Command channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_cmd,
    input  logic [15:0] i_freq_hz,
    input  logic [15:0] i_duration_ticks,
    input  logic [7:0]  i_tune_index,
    input  logic [7:0]  i_entry_key,
    // Result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_tone_on,
    output logic [7:0]  o_compare_value,
    output logic        o_busy_res,
    output logic        o_tune_playing
);

    // Address width of the tune memory and the dividend width that holds
    // the base frequency plus half of the largest frequency.
    localparam int AW = $clog2(TUNE_DEPTH);
    localparam int DW = $clog2(TONE_BASE_HZ + 32768);
    localparam logic [AW-1:0] LAST_INDEX = AW'(TUNE_DEPTH - 1);

    // Sequencer states.
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_FETCH  = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_RESULT = 3'd4;

    logic [2:0]  r_state, n_state;

    // Latched command transaction.
    logic [2:0]  r_cmd;
    logic [15:0] r_freq;
    logic [15:0] r_dur;
    logic [7:0]  r_index;
    logic [7:0]  r_key;

    // Player state.
    logic [AW-1:0] r_cur, n_cur;
    logic [AW-1:0] r_start, n_start;
    logic          r_tune_valid, n_tune_valid;
    logic          r_beep, n_beep;
    logic [15:0]   r_rem, n_rem;
    logic          r_tone_en, n_tone_en;
    logic [7:0]    r_cmp, n_cmp;
    logic          r_busy, n_busy;
    logic [7:0]    r_repeat_key;
    logic [7:0]    r_end_key;

    // Result register.
    logic          r_out_valid;
    logic          r_o_tone_on;
    logic [7:0]    r_o_cmp;
    logic          r_o_busy;
    logic          r_o_playing;
    logic          out_free;

    // Shared divider and tune memory connections.
    logic          div_start;
    logic [DW-1:0] div_dividend;
    logic [15:0]   div_divisor;
    logic          div_done;
    logic [DW-1:0] div_q;
    logic          ram_we;
    logic [tmel_pkg::ENTRY_W-1:0] ram_rdata;

    // Decode helpers.
    logic [15:0]   rem_dec;
    logic [7:0]    fetch_key;
    logic [15:0]   fetch_dur;
    logic [15:0]   note_freq;
    logic [15:0]   tone_freq;
    logic [7:0]    cmp_capped;
    logic [AW-1:0] wrap_idx;

    // Tune index modulo the tune depth. The index is below 256 and the depth
    // is at least 4, so six conditional subtractions of the shifted depth
    // leave the remainder.
    function automatic logic [AW-1:0] wrap_index(input logic [7:0] idx);
        logic [19:0] rest;
        rest = {12'd0, idx};
        for (int k = 5; k >= 0; k--) begin
            if (rest >= 20'(TUNE_DEPTH << k)) begin
                rest = rest - 20'(TUNE_DEPTH << k);
            end
        end
        return AW'(rest);
    endfunction

    tmel_div #(
        .DW(DW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // The read address follows the current index, so the entry is ready in the
    // cycle after the tick has been decoded.
    tmel_ram #(
        .WIDTH(tmel_pkg::ENTRY_W),
        .DEPTH(TUNE_DEPTH)
    ) u_tune_mem (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (wrap_idx),
        .i_wdata ({r_key, r_dur}),
        .i_raddr (r_cur),
        .o_rdata (ram_rdata)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;

    assign wrap_idx  = wrap_index(r_index);
    assign rem_dec   = (r_rem != 16'd0) ? (r_rem - 16'd1) : r_rem;
    assign fetch_key = ram_rdata[23:16];
    assign fetch_dur = ram_rdata[15:0];
    // Keys past the end of the piano table play as silence.
    assign note_freq = (fetch_key < tmel_pkg::KEY_COUNT)
                     ? tmel_pkg::KEY_FREQ[fetch_key[6:0]] : 16'd0;
    assign tone_freq = (r_state == S_FETCH) ? note_freq : r_freq;

    // Tones divide the base frequency, rounded by adding half the divisor.
    assign div_dividend = DW'(TONE_BASE_HZ) + DW'(tone_freq >> 1);
    assign div_divisor  = tone_freq;

    // Compare value is the quotient minus one, saturated to 0..255.
    always_comb begin
        if (div_q == '0) begin
            cmp_capped = 8'd0;
        end else if (div_q > DW'(256)) begin
            cmp_capped = tmel_pkg::COMPARE_MAX;
        end else begin
            cmp_capped = 8'(div_q - DW'(1));
        end
    end

    always_comb begin
        n_state      = r_state;
        n_cur        = r_cur;
        n_start      = r_start;
        n_tune_valid = r_tune_valid;
        n_beep       = r_beep;
        n_rem        = r_rem;
        n_tone_en    = r_tone_en;
        n_cmp        = r_cmp;
        n_busy       = r_busy;
        div_start    = 1'b0;
        ram_we       = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_busy  = 1'b0;
                n_state = S_RESULT;
                case (r_cmd)
                    tmel_pkg::CMD_TICK: begin
                        n_rem = rem_dec;
                        if (r_beep) begin
                            // A running beep overrides the tune.
                            if (rem_dec != 16'd0) begin
                                n_busy = 1'b1;
                            end else begin
                                n_tone_en = 1'b0;
                                n_beep    = 1'b0;
                            end
                        end else if (!r_tune_valid) begin
                            n_tone_en = 1'b0;
                        end else if (rem_dec != 16'd0) begin
                            n_busy = 1'b1;
                        end else begin
                            n_state = S_FETCH;
                        end
                    end
                    tmel_pkg::CMD_BEEP: begin
                        n_rem  = r_dur;
                        n_beep = 1'b1;
                        if (r_freq == 16'd0) begin
                            n_tone_en = 1'b0;
                        end else begin
                            div_start = 1'b1;
                            n_state   = S_DIV;
                        end
                    end
                    tmel_pkg::CMD_PLAY: begin
                        n_start      = wrap_idx;
                        n_cur        = wrap_idx;
                        n_tune_valid = 1'b1;
                        n_rem        = 16'd0;
                    end
                    tmel_pkg::CMD_WRITE: begin
                        ram_we = 1'b1;
                    end
                    tmel_pkg::CMD_OFF: begin
                        n_tone_en = 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
            S_FETCH: begin
                n_state = S_RESULT;
                if ((fetch_key == r_repeat_key) && (fetch_dur == 16'd0)) begin
                    n_tone_en = 1'b0;
                    n_cur     = r_start;
                    n_busy    = 1'b1;
                end else if ((fetch_key == r_end_key) && (fetch_dur == 16'd0)) begin
                    n_tone_en    = 1'b0;
                    n_tune_valid = 1'b0;
                end else begin
                    n_rem  = fetch_dur;
                    n_cur  = (r_cur == LAST_INDEX) ? '0 : (r_cur + AW'(1));
                    n_busy = 1'b1;
                    if (note_freq == 16'd0) begin
                        n_tone_en = 1'b0;
                    end else begin
                        div_start = 1'b1;
                        n_state   = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state   = S_RESULT;
                    n_cmp     = cmp_capped;
                    n_tone_en = 1'b1;
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cur        <= '0;
            r_start      <= '0;
            r_tune_valid <= 1'b0;
            r_beep       <= 1'b0;
            r_rem        <= 16'd0;
            r_tone_en    <= 1'b0;
            r_cmp        <= 8'd0;
            r_busy       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cur        <= n_cur;
            r_start      <= n_start;
            r_tune_valid <= n_tune_valid;
            r_beep       <= n_beep;
            r_rem        <= n_rem;
            r_tone_en    <= n_tone_en;
            r_cmp        <= n_cmp;
            r_busy       <= n_busy;
            if ((r_state == S_RESULT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repeat_key <= 8'd254;
            r_end_key    <= 8'd255;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tmel_pkg::CFG_REPEAT_KEY: r_repeat_key <= i_cfg_data;
                tmel_pkg::CFG_END_KEY:    r_end_key    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Command payload capture and result payload.
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_in_valid) begin
            r_cmd   <= i_cmd;
            r_freq  <= i_freq_hz;
            r_dur   <= i_duration_ticks;
            r_index <= i_tune_index;
            r_key   <= i_entry_key;
        end
        if ((r_state == S_RESULT) && out_free) begin
            r_o_tone_on <= r_tone_en;
            r_o_cmp     <= r_tone_en ? r_cmp : 8'd0;
            r_o_busy    <= r_busy;
            r_o_playing <= r_tune_valid;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_tone_on       = r_o_tone_on;
    assign o_compare_value = r_o_cmp;
    assign o_busy_res      = r_o_busy;
    assign o_tune_playing  = r_o_playing;

endmodule
